/* hw/rtl/psg_pkg.sv */
`default_nettype none

package psg_pkg;

   // shadow file size; the index width is fixed by the 4-bit event_register field
   localparam int unsigned REGISTER_COUNT_DEF = 16;
   localparam int unsigned SHADOW_AW          = 4;

   // first mapping: masked compares
   localparam logic [15:0] FIRST_MASK   = 16'hc002;
   localparam logic [15:0] FIRST_SELECT = 16'hfffd & FIRST_MASK;
   localparam logic [15:0] FIRST_WRITE  = 16'hbffd & FIRST_MASK;
   localparam logic [15:0] BEEPER_MASK  = 16'h0001;
   localparam int unsigned BEEPER_BIT   = 4;

   // second mapping: high byte of port
   localparam logic [15:0] SECOND_HI_MASK = 16'hff00;
   localparam logic [15:0] SECOND_LATCH   = 16'hf400;
   localparam logic [15:0] SECOND_CTRL    = 16'hf600;

   // control codes, data[7:6]
   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd2;
   localparam logic [1:0] CMD_SELECT = 2'd3;

   localparam logic [7:0] READ_NONE = 8'hff;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_REG  = 2'd1,
      EV_BEEP = 2'd2
   } ev_kind_type;

   typedef struct packed {
      logic [31:0]    ev_time;
      logic [7:0]     ev_value;
      logic [3:0]     ev_reg;
      logic [7:0]     read_data;
      ev_kind_type    kind;
   } rsp_word_type;

   typedef struct packed {
      logic                 wr_en;
      logic [SHADOW_AW-1:0] wr_addr;
      logic [7:0]           wr_data;
      logic                 rd_en;
      logic [SHADOW_AW-1:0] rd_addr;
   } ram_ctl_type;

endpackage

`default_nettype wire

/* hw/rtl/psg_shadow_ram.sv */
`default_nettype none

module psg_shadow_ram import psg_pkg::*; #(
   parameter int unsigned DEPTH = REGISTER_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ram_ctl_type ctl,
   output logic [7:0]       rd_data
);

   logic [7:0]       mem [DEPTH];
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [7:0]       rd_mem_ff;
   logic             rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_en) begin
         valid_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_mem_ff   <= mem[ctl.rd_addr];
         rd_valid_ff <= valid_ff[ctl.rd_addr];
      end
   end

   // never-written entries read as their reset value of zero
   assign rd_data = rd_valid_ff ? rd_mem_ff : 8'h00;

endmodule

`default_nettype wire

/* hw/rtl/psg_skid.sv */
`default_nettype none

module psg_skid import psg_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire rsp_word_type in_word,
   output logic              out_valid,
   input  wire logic         out_ready,
   output rsp_word_type      out_word
);

   logic         out_valid_ff, skid_valid_ff;
   rsp_word_type out_word_ff, skid_word_ff;
   logic         in_fire;

   assign in_ready = !skid_valid_ff;
   assign in_fire  = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= in_fire;
         end
      end else if (in_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || out_ready) begin
         out_word_ff <= skid_valid_ff ? skid_word_ff : in_word;
      end else if (in_fire) begin
         skid_word_ff <= in_word;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

endmodule

`default_nettype wire

/* hw/rtl/psg_port_decoder_dual_mapping.sv */
// Port decoder for a sound generator chip under two machine mappings.
// req_*: one word per CPU I/O access (tuser = read/write, tdata = port, byte,
// tick). rsp_*: exactly one word per access, in order: read byte (0xff when
// nothing decodes), and an optional register-write or beeper-change event.
// csr_*: single-bit block_events; when set, state still updates but the event
// kind is reported as none. csr_ready is always high.
// Throughput: one access per cycle unless a stalled receiver holds it back.
// Decode and state update happen in the accept cycle; the shadow register
// file is a synchronous RAM read at the same edge. The response sits in a
// stage register, then moves to the output register, from which the
// receiver takes it. Back-to-back accesses to the same shadow entry need no
// bypass, as a write lands at its accept edge, before any later read issues.
// A stalled receiver fills the output register, then a skid word, then the
// response stage; req_tready drops once all three are held, and never depends
// combinationally on rsp_tready. Reset (synchronous) selects register 0,
// clears the beeper, latch and pending command, returns to the first mapping,
// and marks all shadow entries as zero via per-entry valid bits; no clearing
// pass is needed.
`default_nettype none

module psg_port_decoder_dual_mapping import psg_pkg::*; #(
   parameter int unsigned REGISTER_COUNT = REGISTER_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // port_address, write_data, time_stamp
   input  wire logic [0:0]  req_tuser,   // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // read_data, event_register, event_value,
                                         // event_time, zero pad
   output logic [1:0]       rsp_tuser,   // event_kind
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data     // block_events
);

   localparam logic [7:0] REG_LIMIT = 8'(REGISTER_COUNT);

   logic        action;
   logic [15:0] port;
   logic [7:0]  wdata;
   logic [31:0] tstamp;

   assign action = req_tuser[0];
   assign port   = req_tdata[15:0];
   assign wdata  = req_tdata[23:16];
   assign tstamp = req_tdata[55:24];

   // control state
   logic [7:0] sel_ff, sel_in;
   logic       beep_ff, beep_in;
   logic [7:0] latch_ff, latch_in;
   logic [1:0] cmd_ff, cmd_in;
   logic       active_ff, active_in;
   logic       block_ff;

   // response stage
   logic         s1_valid_ff, s1_valid_in;
   logic         s1_hit_ff;
   ev_kind_type  s1_kind_ff;
   logic [3:0]   s1_reg_ff;
   logic [7:0]   s1_val_ff;
   logic [31:0]  s1_time_ff;

   logic         req_fire;
   logic         skid_ready;
   ram_ctl_type  ram_ctl;
   logic [7:0]   ram_rd;
   rsp_word_type s1_word, out_word;

   // decode results
   logic         rd_hit;
   logic         wr_en;
   logic [7:0]   wr_val;
   logic [7:0]   sel_mid;
   logic         sm_ok;
   ev_kind_type  ev_kind;
   logic [3:0]   ev_reg;
   logic [7:0]   ev_val;
   logic [31:0]  ev_time;
   logic [1:0]   code;
   logic         is_latch, is_ctrl;
   logic [15:0]  first_m;

   assign req_tready = !s1_valid_ff || skid_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      code     = wdata[7:6];
      is_latch = (port & SECOND_HI_MASK) == SECOND_LATCH;
      is_ctrl  = (port & SECOND_HI_MASK) == SECOND_CTRL;
      first_m  = port & FIRST_MASK;

      sel_mid   = sel_ff;
      sel_in    = sel_ff;
      sm_ok     = 1'b0;
      wr_en     = 1'b0;
      wr_val    = wdata;
      beep_in   = beep_ff;
      latch_in  = latch_ff;
      cmd_in    = cmd_ff;
      ev_kind   = EV_NONE;
      ev_reg    = 4'd0;
      ev_val    = 8'd0;
      ev_time   = 32'd0;
      rd_hit    = !action && !active_ff && first_m == FIRST_SELECT && sel_ff < REG_LIMIT;

      if (action) begin
         // second mapping is always tried first
         if (is_latch) begin
            latch_in = wdata;
         end
         if (is_ctrl) begin
            if (cmd_ff == CMD_NONE) begin
               cmd_in = code;
            end else if (code == CMD_NONE) begin
               cmd_in = CMD_NONE;
               if (cmd_ff == CMD_SELECT) begin
                  sel_mid = latch_ff;
                  sm_ok   = latch_ff < REG_LIMIT;
               end else if (cmd_ff == CMD_WRITE && sel_ff < REG_LIMIT) begin
                  sm_ok  = 1'b1;
                  wr_en  = 1'b1;
                  wr_val = latch_ff;
               end
            end
         end
         sel_in = sel_mid;

         if (!active_ff && !sm_ok) begin
            if (first_m == FIRST_SELECT) begin
               sel_in = wdata;
            end else if (first_m == FIRST_WRITE) begin
               wr_en = sel_mid < REG_LIMIT;
            end else if ((port & BEEPER_MASK) == 16'h0000) begin
               beep_in = wdata[BEEPER_BIT];
            end
         end

         if (!block_ff) begin
            if (wr_en) begin
               ev_kind = EV_REG;
               ev_reg  = sel_mid[3:0];
               ev_val  = wr_val;
               ev_time = tstamp;
            end else if (beep_in != beep_ff) begin
               ev_kind = EV_BEEP;
               ev_val  = {7'd0, beep_in};
               ev_time = tstamp;
            end
         end
      end

      active_in   = active_ff || (action && sm_ok);
      s1_valid_in = req_fire || (s1_valid_ff && !skid_ready);
   end

   always_comb begin
      ram_ctl.wr_en   = req_fire && wr_en;
      ram_ctl.wr_addr = sel_mid[SHADOW_AW-1:0];
      ram_ctl.wr_data = wr_val;
      ram_ctl.rd_en   = req_fire && !action;
      ram_ctl.rd_addr = sel_ff[SHADOW_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff      <= 8'd0;
         beep_ff     <= 1'b0;
         latch_ff    <= 8'd0;
         cmd_ff      <= CMD_NONE;
         active_ff   <= 1'b0;
         block_ff    <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            sel_ff    <= sel_in;
            beep_ff   <= beep_in;
            latch_ff  <= latch_in;
            cmd_ff    <= cmd_in;
            active_ff <= active_in;
         end
         if (csr_valid && csr_ready) begin
            block_ff <= csr_data;
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_hit_ff  <= rd_hit;
         s1_kind_ff <= ev_kind;
         s1_reg_ff  <= ev_reg;
         s1_val_ff  <= ev_val;
         s1_time_ff <= ev_time;
      end
   end

   psg_shadow_ram #(
      .DEPTH (REGISTER_COUNT)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ram_ctl),
      .rd_data (ram_rd)
   );

   always_comb begin
      s1_word.kind      = s1_kind_ff;
      s1_word.read_data = s1_hit_ff ? ram_rd : READ_NONE;
      s1_word.ev_reg    = s1_reg_ff;
      s1_word.ev_value  = s1_val_ff;
      s1_word.ev_time   = s1_time_ff;
   end

   psg_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (skid_ready),
      .in_word   (s1_word),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (out_word)
   );

   assign rsp_tdata = {4'd0, out_word.ev_time, out_word.ev_value, out_word.ev_reg,
                       out_word.read_data};
   assign rsp_tuser = out_word.kind;

`ifndef SYNTHESIS
   a_active_sticky: assert property (@(posedge clock) disable iff (reset)
      active_ff |=> active_ff)
      else $error("second mapping dropped back to first");

   a_event_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != EV_NONE |-> rsp_tdata[7:0] == READ_NONE)
      else $error("event response carries read data");

   a_blocked_quiet: assert property (@(posedge clock) disable iff (reset)
      req_fire && block_ff |=> s1_kind_ff == EV_NONE)
      else $error("event emitted while blocked");

   a_second_read: assert property (@(posedge clock) disable iff (reset)
      req_fire && !action && active_ff |=> !s1_hit_ff)
      else $error("readback decoded in second mapping");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !skid_ready |=> s1_valid_ff && $stable(s1_kind_ff))
      else $error("response stage lost a word under stall");
`endif

endmodule

`default_nettype wire
